FILE: src/lzwe_pkg.sv
// Package for the LZW variable-width encoder.
// Holds the dictionary sizes, code widths, item and entry types and the hash function.
// Used by every module of the encoder; depends on nothing.
package lzwe_pkg;

  localparam int DICT_ENTRIES   = 4096;
  localparam int MIN_CODE_WIDTH = 9;
  localparam int MAX_CODE_WIDTH = 12;
  localparam int BYTE_CODES     = 256;

  localparam int CODE_W    = $clog2(DICT_ENTRIES);
  localparam int NF_W      = CODE_W + 1;
  localparam int KEY_W     = CODE_W + 8;
  localparam int HASH_BITS = CODE_W + 1;
  localparam int SLOTS     = 2 ** HASH_BITS;
  localparam int EPOCH_W   = 3;
  localparam int WIDTH_W   = 5;

  localparam int OUT_CODE_W = 12;
  localparam int OUT_BITS_W = 4;

  typedef struct packed {
    logic       eos;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic                  final_code;
    logic [OUT_BITS_W-1:0] code_bits;
    logic [OUT_CODE_W-1:0] out_code;
  } out_item_t;

  typedef struct packed {
    logic               used;
    logic [EPOCH_W-1:0] epoch;
    logic [CODE_W-1:0]  code;
    logic [KEY_W-1:0]   key;
  } entry_t;

  function automatic logic [HASH_BITS-1:0] hash_key(input logic [CODE_W-1:0] prefix,
                                                    input logic [7:0] data_byte);
    logic [HASH_BITS-1:0] h;
    h = {1'b0, prefix} ^ (HASH_BITS'(data_byte) << (HASH_BITS - 8));
    return h;
  endfunction

  function automatic logic [OUT_CODE_W-1:0] to_out_code(input logic [CODE_W-1:0] c);
    logic [31:0] tmp;
    tmp = 32'(c);
    return tmp[OUT_CODE_W-1:0];
  endfunction

endpackage

FILE: src/lzwe_front.sv
// Input side of the LZW encoder: a two-entry queue of accepted bytes.
// Depends on lzwe_pkg for the input item type.
module lzwe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // data_byte [7:0]
  input  logic              s_tlast,   // end_of_stream
  output logic              item_valid,
  output lzwe_pkg::in_item_t item,
  input  logic              item_pop
);

  lzwe_pkg::in_item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign item_valid = (count != 2'd0);
  assign item       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{eos: s_tlast, data_byte: s_tdata};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(item_pop);
    end
  end

endmodule

FILE: src/lzwe_out_buf.sv
// Output side of the LZW encoder: a two-entry queue of emitted codes.
// Depends on lzwe_pkg for the output item type.
module lzwe_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lzwe_pkg::out_item_t item,
  output logic               empty,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,  // out_code [11:0], code_bits [15:12]
  output logic               m_tlast   // final_code
);

  lzwe_pkg::out_item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign empty    = (count == 2'd0);
  assign m_tvalid = !empty;
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = {entries[rd_ptr].code_bits, entries[rd_ptr].out_code};
  assign m_tlast  = entries[rd_ptr].final_code;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: src/lzwe_core.sv
// Back end of the LZW encoder: match state, hashed dictionary memory and probe sequencer.
// Depends on lzwe_pkg; fed by lzwe_front and feeding lzwe_out_buf.
module lzwe_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  lzwe_pkg::in_item_t item,
  output logic               item_pop,
  input  logic               out_empty,
  output logic               out_push,
  output lzwe_pkg::out_item_t out_item
);

  typedef enum logic [2:0] {CLEAR, IDLE, PROBE, CHECK, FINISH} state_t;

  state_t state;
  logic [lzwe_pkg::CODE_W-1:0]    match_code;
  logic                           match_valid;
  logic [lzwe_pkg::NF_W-1:0]      next_free;
  logic [lzwe_pkg::WIDTH_W-1:0]   cur_width;
  logic                           table_full;
  logic [lzwe_pkg::EPOCH_W-1:0]   epoch;
  logic [7:0]                     cur_byte;
  logic                           cur_eos;
  logic [lzwe_pkg::HASH_BITS-1:0] probe_addr;
  logic [lzwe_pkg::HASH_BITS-1:0] clr_addr;

  lzwe_pkg::entry_t mem [lzwe_pkg::SLOTS];
  lzwe_pkg::entry_t rd_entry;

  logic                           mem_we;
  logic [lzwe_pkg::HASH_BITS-1:0] mem_waddr;
  lzwe_pkg::entry_t               mem_wdata;

  logic                         slot_live;
  logic                         key_hit;
  logic [lzwe_pkg::KEY_W-1:0]   cur_key;
  logic [lzwe_pkg::NF_W-1:0]    nf_inc;
  logic [lzwe_pkg::NF_W+1:0]    width_limit;
  logic [lzwe_pkg::EPOCH_W-1:0] epoch_next;

  assign cur_key     = {match_code, cur_byte};
  assign slot_live   = rd_entry.used && (rd_entry.epoch == epoch);
  assign key_hit     = slot_live && (rd_entry.key == cur_key);
  assign nf_inc      = next_free + 1'b1;
  assign width_limit = (lzwe_pkg::NF_W+2)'(1) << cur_width;
  assign epoch_next  = epoch + 1'b1;

  always_comb begin
    item_pop  = (state == IDLE) && item_valid && out_empty;
    mem_we    = 1'b0;
    mem_waddr = probe_addr;
    mem_wdata = '{used: 1'b1, epoch: epoch, code: next_free[lzwe_pkg::CODE_W-1:0],
                  key: cur_key};
    out_push  = 1'b0;
    out_item  = '{final_code: 1'b0, code_bits: cur_width[lzwe_pkg::OUT_BITS_W-1:0],
                  out_code: lzwe_pkg::to_out_code(match_code)};
    unique case (state)
      CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      CHECK: begin
        if (!slot_live) begin
          out_push = 1'b1;
          mem_we   = !table_full;
        end
      end
      FINISH: begin
        out_push            = 1'b1;
        out_item.final_code = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_entry <= mem[probe_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= CLEAR;
      clr_addr    <= '0;
      match_code  <= '0;
      match_valid <= 1'b0;
      next_free   <= lzwe_pkg::NF_W'(lzwe_pkg::BYTE_CODES);
      cur_width   <= lzwe_pkg::WIDTH_W'(lzwe_pkg::MIN_CODE_WIDTH);
      table_full  <= 1'b0;
      epoch       <= '0;
      cur_byte    <= '0;
      cur_eos     <= 1'b0;
      probe_addr  <= '0;
    end else begin
      unique case (state)
        CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == lzwe_pkg::HASH_BITS'(lzwe_pkg::SLOTS - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (item_pop) begin
            cur_byte <= item.data_byte;
            cur_eos  <= item.eos;
            if (!match_valid) begin
              match_code  <= lzwe_pkg::CODE_W'(item.data_byte);
              match_valid <= 1'b1;
              if (item.eos) begin
                state <= FINISH;
              end
            end else begin
              probe_addr <= lzwe_pkg::hash_key(match_code, item.data_byte);
              state      <= PROBE;
            end
          end
        end
        PROBE: begin
          state <= CHECK;
        end
        CHECK: begin
          if (key_hit) begin
            match_code <= rd_entry.code;
            state      <= cur_eos ? FINISH : IDLE;
          end else if (slot_live) begin
            probe_addr <= probe_addr + 1'b1;
            state      <= PROBE;
          end else begin
            if (!table_full) begin
              next_free <= nf_inc;
              if ((lzwe_pkg::NF_W+2)'(nf_inc) == width_limit &&
                  cur_width < lzwe_pkg::WIDTH_W'(lzwe_pkg::MAX_CODE_WIDTH)) begin
                cur_width <= cur_width + 1'b1;
              end
              if (nf_inc >= lzwe_pkg::NF_W'(lzwe_pkg::DICT_ENTRIES)) begin
                table_full <= 1'b1;
              end
            end
            match_code <= lzwe_pkg::CODE_W'(cur_byte);
            state      <= cur_eos ? FINISH : IDLE;
          end
        end
        FINISH: begin
          match_valid <= 1'b0;
          match_code  <= '0;
          next_free   <= lzwe_pkg::NF_W'(lzwe_pkg::BYTE_CODES);
          cur_width   <= lzwe_pkg::WIDTH_W'(lzwe_pkg::MIN_CODE_WIDTH);
          table_full  <= 1'b0;
          epoch       <= epoch_next;
          if (epoch_next == '0) begin
            clr_addr <= '0;
            state    <= CLEAR;
          end else begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/lzw_variable_width_encoder.sv
// LZW variable-width encoder, top level.
// Instantiates lzwe_front, lzwe_core and lzwe_out_buf; depends on lzwe_pkg.
//
// Usage: bytes arrive on the s_ channel, one per transfer, with s_tlast on the
// final byte of a stream. Codes leave on the m_ channel, one per transfer, with
// the code width in bits alongside and m_tlast on the last code of a stream.
// A byte that extends the current match gives no code; a byte that breaks the
// match gives one code; the end-of-stream byte gives one or two codes.
// A byte that starts a stream needs no lookup; any other byte is looked up in the
// dictionary through the PROBE and CHECK states. A byte that gives a code holds
// the next byte until the code has left the output queue. The dictionary is a
// hashed memory with linear probing and one read per probe; each extra probe
// repeats PROBE and CHECK. A stream end adds the FINISH state.
// After reset, and after every eighth stream, all 8192 slots of the dictionary
// memory are swept; bytes are queued (two deep) but not processed during the sweep.
// A byte is processed only once the output queue is empty, so a stalled
// receiver holds the block after at most two waiting codes; nothing is dropped.
module lzw_variable_width_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte [7:0]
  input  logic        s_tlast,   // end_of_stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_code [11:0], code_bits [15:12]
  output logic        m_tlast    // final_code
);

  logic                item_valid;
  lzwe_pkg::in_item_t  item;
  logic                item_pop;
  logic                out_empty;
  logic                out_push;
  lzwe_pkg::out_item_t out_item;

  lzwe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  lzwe_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_empty  (out_empty),
    .out_push   (out_push),
    .out_item   (out_item)
  );

  lzwe_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (out_push),
    .item     (out_item),
    .empty    (out_empty),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: src/lzwe_checker.sv
// Port-level checks for the LZW encoder, bound to the top level.
// Depends on lzwe_pkg for the code width limits.
module lzwe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Output valid right after reset.");

  a_ready_after_reset: assert property (@(posedge clk) rst |=> s_tready)
    else $error("Input not ready right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Stalled output transfer changed.");

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:12] >= 4'(lzwe_pkg::MIN_CODE_WIDTH) &&
                 m_tdata[15:12] <= 4'(lzwe_pkg::MAX_CODE_WIDTH))
    else $error("Code width out of range.");

  a_code_fits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[15:12] == 4'd9 |-> m_tdata[11:9] == 3'd0)
    else $error("Code does not fit its width.");

endmodule

bind lzw_variable_width_encoder lzwe_checker u_chk (.*);

FILE: tb/sv/lzw_variable_width_encoder_test.sv
// Testbench for the LZW variable-width encoder: streams of bytes go in, codes come out.
// A behavioral dictionary predicts every code, width and end flag; depends on lzwe_pkg.
`timescale 1ns / 1ps

module lzw_variable_width_encoder_test;

  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct {
    logic [7:0]                      data_byte;
    logic                            eos;
    logic                            has_code;
    logic [lzwe_pkg::OUT_CODE_W-1:0] code;
    logic [lzwe_pkg::OUT_BITS_W-1:0] bits;
    logic                            fin;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  lzw_variable_width_encoder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #10 clk = ~clk;

  // Predicted dictionary state.
  int unsigned dict_key [lzwe_pkg::DICT_ENTRIES];
  int unsigned cur_match;
  bit          match_live;
  int unsigned free_code;
  int unsigned cur_bits;
  bit          dict_full;

  lzwe_pkg::out_item_t code_queue[$];
  lzwe_pkg::out_item_t code_log[$];
  int                  errors = 0;
  int                  idle_cycles = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic void clear_dictionary();
    cur_match = 0;
    match_live = 0;
    free_code = lzwe_pkg::BYTE_CODES;
    cur_bits = lzwe_pkg::MIN_CODE_WIDTH;
    dict_full = 0;
  endfunction

  function automatic void add_code(int unsigned code, int unsigned bits, bit fin);
    lzwe_pkg::out_item_t o;
    o.out_code = code[lzwe_pkg::OUT_CODE_W-1:0];
    o.code_bits = bits[lzwe_pkg::OUT_BITS_W-1:0];
    o.final_code = fin;
    code_queue = {code_queue, o};
    code_log = {code_log, o};
  endfunction

  function automatic void encode_byte(logic [7:0] b, logic eos);
    int unsigned key;
    int          hit;
    hit = -1;
    key = (cur_match << 8) | 32'(b);
    if (!match_live) begin
      cur_match = 32'(b);
      match_live = 1;
    end else begin
      for (int unsigned i = lzwe_pkg::BYTE_CODES;
           i < free_code && i < lzwe_pkg::DICT_ENTRIES; i++) begin
        if (dict_key[i] == key) begin
          hit = int'(i);
          break;
        end
      end
      if (hit >= 0) begin
        cur_match = 32'(hit);
      end else begin
        add_code(cur_match, cur_bits, 1'b0);
        if (!dict_full) begin
          if (free_code < lzwe_pkg::DICT_ENTRIES) dict_key[free_code] = key;
          free_code++;
          if (free_code == (1 << cur_bits) && cur_bits < lzwe_pkg::MAX_CODE_WIDTH) cur_bits++;
          if (free_code >= lzwe_pkg::DICT_ENTRIES) dict_full = 1;
        end
        cur_match = 32'(b);
      end
    end
    if (eos) begin
      add_code(cur_match, cur_bits, 1'b1);
      clear_dictionary();
    end
  endfunction

  // Directed table; a typed-in code is checked against the prediction's first new entry.
  stim_row_t directed[] = '{
    '{8'h00, 1'b1, 1'b1, 12'd0,   4'd9, 1'b1},
    '{8'hFF, 1'b1, 1'b1, 12'd255, 4'd9, 1'b1},
    '{8'h41, 1'b0, 1'b0, 12'd0,   4'd0, 1'b0},
    '{8'h41, 1'b0, 1'b1, 12'd65,  4'd9, 1'b0},
    '{8'h41, 1'b0, 1'b0, 12'd0,   4'd0, 1'b0},
    '{8'h41, 1'b0, 1'b1, 12'd256, 4'd9, 1'b0},
    '{8'h42, 1'b1, 1'b1, 12'd65,  4'd9, 1'b0},
    '{8'h80, 1'b0, 1'b0, 12'd0,   4'd0, 1'b0},
    '{8'h7F, 1'b0, 1'b0, 12'd0,   4'd0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 12'd0,   4'd0, 1'b0},
    '{8'h7F, 1'b1, 1'b0, 12'd0,   4'd0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 12'd0,   4'd0, 1'b0},
    '{8'h01, 1'b1, 1'b0, 12'd0,   4'd0, 1'b0}
  };

  task automatic send_byte(input logic [7:0] b, input logic eos, input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Expectations are queued at the input transfer edge, before any output can follow.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) encode_byte(s_tdata, s_tlast);
    if (!rst && m_tvalid && m_tready) begin
      if (code_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected code %h", m_tdata));
      end else begin
        lzwe_pkg::out_item_t e;
        e = code_queue.pop_front();
        if (m_tdata[11:0] !== e.out_code)
          report_mismatch($sformatf("code %0d, expected %0d", m_tdata[11:0], e.out_code));
        if (m_tdata[15:12] !== e.code_bits)
          report_mismatch($sformatf("width %0d, expected %0d", m_tdata[15:12], e.code_bits));
        if (m_tlast !== e.final_code)
          report_mismatch($sformatf("last %b, expected %b", m_tlast, e.final_code));
      end
    end
  end

  // Receiver stalls in a pattern of its own, with quiet stretches.
  always @(negedge clk) begin
    int unsigned phase;
    phase = $urandom_range(0, 99);
    if ($realtime < 200000.0 * 100 && phase < 30) m_tready <= 1'b0;
    else m_tready <= (phase < 80) || ($urandom_range(0, 1) == 1);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int                  sent;
    int                  len;
    int                  alpha;
    logic [7:0]          b;
    lzwe_pkg::out_item_t seen;
    clear_dictionary();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      int before_n;
      before_n = code_log.size();
      send_byte(directed[i].data_byte, directed[i].eos, 0);
      if (directed[i].has_code) begin
        if (code_log.size() <= before_n) begin
          report_mismatch($sformatf("row %0d gave no code", i));
        end else begin
          seen = code_log[before_n];
          if (seen.out_code != directed[i].code || seen.code_bits != directed[i].bits ||
              seen.final_code != directed[i].fin)
            report_mismatch($sformatf("row %0d table value differs", i));
        end
      end
    end
    s_tvalid <= 1'b0;
    while (code_queue.size() != 0) @(negedge clk);

    // One long stream of random bytes grows the dictionary past the first width step.
    for (int k = 0; k < 600; k++) begin
      b = 8'($urandom_range(0, 255));
      send_byte(b, k == 599, 1);
    end
    s_tvalid <= 1'b0;

    sent = 0;
    while (sent < 950) begin
      len = $urandom_range(0, 9) == 0 ? $urandom_range(100, 400) : $urandom_range(1, 30);
      alpha = $urandom_range(0, 2) == 0 ? 255 : $urandom_range(1, 7);
      for (int k = 0; k < len; k++) begin
        b = 8'($urandom_range(0, alpha));
        send_byte(b, k == len - 1, 1);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        s_tvalid <= 1'b0;
        while (code_queue.size() != 0) @(negedge clk);
      end
    end
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;

    while (code_queue.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
